// ===== hdl/sodpr_pkg.sv =====
`default_nettype none

package sodpr_pkg;

	// field widths
	localparam int TIME_W   = 48;
	localparam int AXIS_W   = 32;
	localparam int MAG_W    = AXIS_W + 1;
	localparam int MUL_W    = 2 * MAG_W;
	localparam int SQ_W     = 64;
	localparam int DVD_W    = 52;
	localparam int QUO_W    = 32;
	localparam int IVL_W    = 20;
	localparam int THR_W    = 31;
	localparam int ADDR_W   = 4;
	localparam int DATA_W   = 32;
	localparam int NUM_AXES = 3;
	localparam int AX_W     = 2;

	localparam logic [AX_W-1:0] AX_FIRST = '0;
	localparam logic [AX_W-1:0] AX_LAST  = AX_W'(NUM_AXES - 1);

	// timing constants
	localparam logic [TIME_W-1:0] MIN_DT_US        = TIME_W'(100);
	localparam logic [TIME_W-1:0] HEARTBEAT_FACTOR = TIME_W'(3);
	localparam logic [MAG_W-1:0]  VEL_SCALE        = MAG_W'(1000000);

	// velocity saturation limits
	localparam logic [QUO_W-1:0] VEL_POS_MAX = 32'h7FFF_FFFF;
	localparam logic [QUO_W-1:0] VEL_NEG_MAX = 32'h8000_0000;

	// register reset values
	localparam logic [IVL_W-1:0] INTERVAL_RST = IVL_W'(50000);
	localparam logic [THR_W-1:0] THR_RST      = THR_W'(655);

	typedef enum logic [1:0] {
		REG_ENABLE   = 2'd0,
		REG_INTERVAL = 2'd1,
		REG_MOVE_THR = 2'd2,
		REG_ROT_THR  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic             enable;
		logic [IVL_W-1:0] update_interval_us;
		logic [THR_W-1:0] move_threshold;
		logic [THR_W-1:0] rot_threshold;
	} cfg_t;

	typedef struct packed {
		logic                     tick_valid;
		logic                     force_send;
		logic [TIME_W-1:0]        now_us;
		logic signed [AXIS_W-1:0] pos_x;
		logic signed [AXIS_W-1:0] pos_y;
		logic signed [AXIS_W-1:0] pos_z;
		logic signed [AXIS_W-1:0] rot_x;
		logic signed [AXIS_W-1:0] rot_y;
		logic signed [AXIS_W-1:0] rot_z;
	} tick_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0] out_pos_x;
		logic signed [AXIS_W-1:0] out_pos_y;
		logic signed [AXIS_W-1:0] out_pos_z;
		logic signed [AXIS_W-1:0] out_rot_x;
		logic signed [AXIS_W-1:0] out_rot_y;
		logic signed [AXIS_W-1:0] out_rot_z;
		logic signed [AXIS_W-1:0] vel_x;
		logic signed [AXIS_W-1:0] vel_y;
		logic signed [AXIS_W-1:0] vel_z;
		logic [TIME_W-1:0]        report_time_us;
		logic                     changed;
	} report_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} div_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_VMUL,
		ST_VSTART,
		ST_VWAIT,
		ST_PMAG,
		ST_PACC,
		ST_TSQ,
		ST_TCMP,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

// ===== hdl/sodpr_regs.sv =====
`default_nettype none

module sodpr_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [sodpr_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [sodpr_pkg::DATA_W-1:0]  pwdata,
	output logic      [sodpr_pkg::DATA_W-1:0]  prdata,
	output logic                               pready,
	output sodpr_pkg::cfg_t                    cfg
);

	sodpr_pkg::reg_idx_t idx;
	logic                wr;

	assign idx    = sodpr_pkg::reg_idx_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.enable             <= 1'b0;
			cfg.update_interval_us <= sodpr_pkg::INTERVAL_RST;
			cfg.move_threshold     <= sodpr_pkg::THR_RST;
			cfg.rot_threshold      <= sodpr_pkg::THR_RST;
		end else if (wr) begin
			unique case (idx)
				sodpr_pkg::REG_ENABLE:   cfg.enable <= pwdata[0];
				sodpr_pkg::REG_INTERVAL: begin
					cfg.update_interval_us <= pwdata[sodpr_pkg::IVL_W-1:0];
				end
				sodpr_pkg::REG_MOVE_THR: begin
					cfg.move_threshold <= pwdata[sodpr_pkg::THR_W-1:0];
				end
				sodpr_pkg::REG_ROT_THR: begin
					cfg.rot_threshold <= pwdata[sodpr_pkg::THR_W-1:0];
				end
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			sodpr_pkg::REG_ENABLE:   prdata = sodpr_pkg::DATA_W'(cfg.enable);
			sodpr_pkg::REG_INTERVAL: prdata = sodpr_pkg::DATA_W'(cfg.update_interval_us);
			sodpr_pkg::REG_MOVE_THR: prdata = sodpr_pkg::DATA_W'(cfg.move_threshold);
			sodpr_pkg::REG_ROT_THR:  prdata = sodpr_pkg::DATA_W'(cfg.rot_threshold);
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/sodpr_div.sv =====
`default_nettype none

// restoring divider, one quotient bit a cycle, flags quotients of 2^32 and up
module sodpr_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [sodpr_pkg::DVD_W-1:0]  dividend,
	input  wire logic [sodpr_pkg::TIME_W-1:0] divisor,
	output sodpr_pkg::div_stat_t              stat,
	output logic      [sodpr_pkg::QUO_W-1:0]  quotient
);

	localparam int HI_W  = sodpr_pkg::DVD_W - sodpr_pkg::QUO_W;
	localparam int CNT_W = $clog2(sodpr_pkg::QUO_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(sodpr_pkg::QUO_W - 1);

	logic                          busy_q;
	logic                          done_q;
	logic                          ovf_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [sodpr_pkg::TIME_W-1:0]  rem_q;
	logic [sodpr_pkg::TIME_W-1:0]  dsr_q;
	logic [sodpr_pkg::QUO_W-1:0]   qs_q;
	logic [sodpr_pkg::TIME_W:0]    trial;
	logic [sodpr_pkg::TIME_W:0]    trial_sub;
	logic                          fits;
	logic                          hi_ovf;

	// upper dividend bits at or above the divisor mean a quotient of 2^32 or more
	assign hi_ovf    = {(sodpr_pkg::TIME_W - HI_W)'(0), dividend[sodpr_pkg::DVD_W-1 -: HI_W]}
	                   >= divisor;
	assign trial     = {rem_q, qs_q[sodpr_pkg::QUO_W-1]};
	assign trial_sub = trial - {1'b0, dsr_q};
	assign fits      = trial >= {1'b0, dsr_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= !hi_ovf;
			done_q <= hi_ovf;
			ovf_q  <= hi_ovf;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {(sodpr_pkg::TIME_W - HI_W)'(0), dividend[sodpr_pkg::DVD_W-1 -: HI_W]};
			qs_q  <= dividend[sodpr_pkg::QUO_W-1:0];
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= trial_sub[sodpr_pkg::TIME_W-1:0];
			end else begin
				rem_q <= trial[sodpr_pkg::TIME_W-1:0];
			end
			qs_q <= {qs_q[sodpr_pkg::QUO_W-2:0], fits};
		end
	end

	assign stat.done = done_q;
	assign stat.ovf  = ovf_q;
	assign quotient  = qs_q;

endmodule

`default_nettype wire

// ===== hdl/send_on_delta_pose_reporter.sv =====
`default_nettype none

// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+-------------------------
// item     | in        | item_valid, item_stall | tick_t, one pose tick
// rpt      | out       | rpt_valid, rpt_stall   | report_t, zero or one
// apb      | in        | psel, penable, pready  | four config registers
//
// when velocity is estimated, a tick runs the shared 32-step divider once per axis
// before the position and threshold checks; without velocity those checks follow directly.
// reset restores the register defaults, clears the previous and last-sent pose and the result valid flag.
// a finished report waits in the result register under rpt_stall; the next tick is
// taken meanwhile and only holds in its last state if a second report is due.
module send_on_delta_pose_reporter (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output logic                              item_stall,
	input  wire sodpr_pkg::tick_t             item,
	output logic                              rpt_valid,
	input  wire logic                         rpt_stall,
	output sodpr_pkg::report_t                rpt,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [sodpr_pkg::ADDR_W-1:0] paddr,
	input  wire logic [sodpr_pkg::DATA_W-1:0] pwdata,
	output logic      [sodpr_pkg::DATA_W-1:0] prdata,
	output logic                              pready
);

	localparam int TW = sodpr_pkg::TIME_W;
	localparam int AW = sodpr_pkg::AXIS_W;
	localparam int MW = sodpr_pkg::MAG_W;
	localparam int NA = sodpr_pkg::NUM_AXES;

	sodpr_pkg::cfg_t       cfg;
	sodpr_pkg::state_t     state_q, state_d;
	sodpr_pkg::div_stat_t  div_stat;
	logic [sodpr_pkg::QUO_W-1:0] div_quo;

	// architectural state
	logic [AW-1:0]  prev_pos_q [NA];
	logic [TW-1:0]  prev_time_q;
	logic           has_prev_q;
	logic [AW-1:0]  sent_pos_q [NA];
	logic [AW-1:0]  sent_rot_q [NA];
	logic [TW-1:0]  sent_time_q;

	// working registers
	sodpr_pkg::tick_t            in_q;
	logic [sodpr_pkg::AX_W-1:0]  ax_q;
	logic [TW-1:0]               dt_q;
	logic                        gate_q;
	logic                        hb_q;
	logic [sodpr_pkg::MUL_W-1:0] prod_q;
	logic [sodpr_pkg::SQ_W-1:0]  sum_q;
	logic [AW-1:0]               vel_q [NA];
	logic                        big_q;
	logic                        rot_q;
	logic                        changed_q;
	sodpr_pkg::report_t          out_q;
	logic                        out_valid_q;

	// control from the sequencer
	logic          item_take;
	logic          out_take;
	logic          can_load;
	logic          ld_check;
	logic          ld_vel;
	logic          ld_pmag;
	logic          ld_acc;
	logic          ld_cmp;
	logic          ld_out;
	logic          ax_step;
	logic          div_start;
	logic [MW-1:0] mul_a;
	logic [MW-1:0] mul_b;

	// per-axis datapath
	logic [AW-1:0] cur_pos [NA];
	logic [AW-1:0] cur_rot [NA];
	logic [MW-1:0] vdiff, pdiff, rdiff;
	logic [MW-1:0] vmag, pmag, rmag;
	logic [AW-1:0] vsat;

	// tick checks
	logic          act;
	logic          chk_vel_en;
	logic [TW-1:0] chk_dt;
	logic [TW-1:0] last_send;
	logic [TW-1:0] elapsed;
	logic [TW-1:0] hb_lim;
	logic          mv;
	logic          report;

	sodpr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sodpr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q[sodpr_pkg::DVD_W-1:0]),
		.divisor  (dt_q),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// handshakes
	assign item_stall = (state_q != sodpr_pkg::ST_IDLE);
	assign item_take  = item_valid && !item_stall;
	assign out_take   = out_valid_q && !rpt_stall;
	assign can_load   = !out_valid_q || !rpt_stall;
	assign rpt_valid  = out_valid_q;
	assign rpt        = out_q;

	// axis views of the captured tick
	assign cur_pos[0] = in_q.pos_x;
	assign cur_pos[1] = in_q.pos_y;
	assign cur_pos[2] = in_q.pos_z;
	assign cur_rot[0] = in_q.rot_x;
	assign cur_rot[1] = in_q.rot_y;
	assign cur_rot[2] = in_q.rot_z;

	// differences and magnitudes of the selected axis
	always_comb begin
		vdiff = {cur_pos[ax_q][AW-1], cur_pos[ax_q]}
		        - {prev_pos_q[ax_q][AW-1], prev_pos_q[ax_q]};
		pdiff = {cur_pos[ax_q][AW-1], cur_pos[ax_q]}
		        - {sent_pos_q[ax_q][AW-1], sent_pos_q[ax_q]};
		rdiff = {cur_rot[ax_q][AW-1], cur_rot[ax_q]}
		        - {sent_rot_q[ax_q][AW-1], sent_rot_q[ax_q]};
		vmag  = vdiff[MW-1] ? (MW'(0) - vdiff) : vdiff;
		pmag  = pdiff[MW-1] ? (MW'(0) - pdiff) : pdiff;
		rmag  = rdiff[MW-1] ? (MW'(0) - rdiff) : rdiff;
	end

	// saturate the quotient to the signed velocity range
	always_comb begin
		if (vdiff[MW-1]) begin
			if (div_stat.ovf || div_quo > sodpr_pkg::VEL_NEG_MAX) begin
				vsat = sodpr_pkg::VEL_NEG_MAX;
			end else begin
				vsat = AW'(0) - div_quo;
			end
		end else begin
			if (div_stat.ovf || div_quo[sodpr_pkg::QUO_W-1]) begin
				vsat = sodpr_pkg::VEL_POS_MAX;
			end else begin
				vsat = div_quo;
			end
		end
	end

	// interval, heartbeat and velocity qualification of the captured tick
	always_comb begin
		act        = cfg.enable && in_q.tick_valid;
		chk_dt     = in_q.now_us - prev_time_q;
		chk_vel_en = has_prev_q && (prev_time_q != '0) && (in_q.now_us >= prev_time_q)
		             && (chk_dt >= sodpr_pkg::MIN_DT_US);
		last_send  = in_q.force_send ? '0 : sent_time_q;
		elapsed    = in_q.now_us - last_send;
		hb_lim     = TW'(cfg.update_interval_us) * sodpr_pkg::HEARTBEAT_FACTOR;
		mv         = big_q || (sum_q > prod_q[sodpr_pkg::SQ_W-1:0]);
		report     = gate_q && (mv || rot_q || hb_q);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sodpr_pkg::ST_IDLE: begin
				if (item_take) state_d = sodpr_pkg::ST_CHECK;
			end
			sodpr_pkg::ST_CHECK: begin
				if (!act) begin
					state_d = sodpr_pkg::ST_IDLE;
				end else if (chk_vel_en) begin
					state_d = sodpr_pkg::ST_VMUL;
				end else begin
					state_d = sodpr_pkg::ST_PMAG;
				end
			end
			sodpr_pkg::ST_VMUL:   state_d = sodpr_pkg::ST_VSTART;
			sodpr_pkg::ST_VSTART: state_d = sodpr_pkg::ST_VWAIT;
			sodpr_pkg::ST_VWAIT: begin
				if (div_stat.done) begin
					state_d = (ax_q == sodpr_pkg::AX_LAST) ? sodpr_pkg::ST_PMAG
					                                       : sodpr_pkg::ST_VMUL;
				end
			end
			sodpr_pkg::ST_PMAG: state_d = sodpr_pkg::ST_PACC;
			sodpr_pkg::ST_PACC: begin
				state_d = (ax_q == sodpr_pkg::AX_LAST) ? sodpr_pkg::ST_TSQ
				                                       : sodpr_pkg::ST_PMAG;
			end
			sodpr_pkg::ST_TSQ:  state_d = sodpr_pkg::ST_TCMP;
			sodpr_pkg::ST_TCMP: begin
				state_d = report ? sodpr_pkg::ST_OUT : sodpr_pkg::ST_IDLE;
			end
			sodpr_pkg::ST_OUT: begin
				if (can_load) state_d = sodpr_pkg::ST_IDLE;
			end
			default: state_d = sodpr_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		ld_check  = 1'b0;
		ld_vel    = 1'b0;
		ld_pmag   = 1'b0;
		ld_acc    = 1'b0;
		ld_cmp    = 1'b0;
		ld_out    = 1'b0;
		ax_step   = 1'b0;
		div_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			sodpr_pkg::ST_CHECK: ld_check = 1'b1;
			sodpr_pkg::ST_VMUL: begin
				mul_a = vmag;
				mul_b = sodpr_pkg::VEL_SCALE;
			end
			sodpr_pkg::ST_VSTART: div_start = 1'b1;
			sodpr_pkg::ST_VWAIT: begin
				ld_vel  = div_stat.done;
				ax_step = div_stat.done;
			end
			sodpr_pkg::ST_PMAG: begin
				ld_pmag = 1'b1;
				mul_a   = pmag;
				mul_b   = pmag;
			end
			sodpr_pkg::ST_PACC: begin
				ld_acc  = 1'b1;
				ax_step = 1'b1;
			end
			sodpr_pkg::ST_TSQ: begin
				mul_a = MW'(cfg.move_threshold);
				mul_b = MW'(cfg.move_threshold);
			end
			sodpr_pkg::ST_TCMP: ld_cmp = 1'b1;
			sodpr_pkg::ST_OUT:  ld_out = can_load;
			default: ;
		endcase
	end

	// sequencer, axis counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sodpr_pkg::ST_IDLE;
			ax_q        <= sodpr_pkg::AX_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ld_check) begin
				ax_q <= sodpr_pkg::AX_FIRST;
			end else if (ax_step) begin
				ax_q <= (ax_q == sodpr_pkg::AX_LAST) ? sodpr_pkg::AX_FIRST
				                                     : ax_q + sodpr_pkg::AX_W'(1);
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// previous tick and last sent report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_time_q <= '0;
			has_prev_q  <= 1'b0;
			sent_time_q <= '0;
			for (int i = 0; i < NA; i++) begin
				prev_pos_q[i] <= '0;
				sent_pos_q[i] <= '0;
				sent_rot_q[i] <= '0;
			end
		end else begin
			if (ld_cmp) begin
				prev_time_q <= in_q.now_us;
				has_prev_q  <= 1'b1;
				for (int i = 0; i < NA; i++) begin
					prev_pos_q[i] <= cur_pos[i];
				end
			end
			if (ld_out) begin
				sent_time_q <= in_q.now_us;
				for (int i = 0; i < NA; i++) begin
					sent_pos_q[i] <= cur_pos[i];
					sent_rot_q[i] <= cur_rot[i];
				end
			end
		end
	end

	// shared multiplier, registered
	always_ff @(posedge clk) begin
		prod_q <= sodpr_pkg::MUL_W'(mul_a) * sodpr_pkg::MUL_W'(mul_b);
	end

	// working datapath
	always_ff @(posedge clk) begin
		if (item_take) begin
			in_q <= item;
		end
		if (ld_check) begin
			dt_q   <= chk_dt;
			gate_q <= (in_q.now_us >= last_send)
			          && (elapsed >= TW'(cfg.update_interval_us));
			hb_q   <= elapsed >= hb_lim;
			sum_q  <= '0;
			big_q  <= 1'b0;
			rot_q  <= 1'b0;
			for (int i = 0; i < NA; i++) begin
				vel_q[i] <= '0;
			end
		end
		if (ld_vel) begin
			vel_q[ax_q] <= vsat;
		end
		if (ld_pmag) begin
			if (pmag > MW'(cfg.move_threshold)) big_q <= 1'b1;
			if (rmag > MW'(cfg.rot_threshold))  rot_q <= 1'b1;
		end
		if (ld_acc) begin
			sum_q <= sum_q + prod_q[sodpr_pkg::SQ_W-1:0];
		end
		if (ld_cmp) begin
			changed_q <= mv || rot_q;
		end
		if (ld_out) begin
			out_q.out_pos_x      <= in_q.pos_x;
			out_q.out_pos_y      <= in_q.pos_y;
			out_q.out_pos_z      <= in_q.pos_z;
			out_q.out_rot_x      <= in_q.rot_x;
			out_q.out_rot_y      <= in_q.rot_y;
			out_q.out_rot_z      <= in_q.rot_z;
			out_q.vel_x          <= vel_q[0];
			out_q.vel_y          <= vel_q[1];
			out_q.vel_z          <= vel_q[2];
			out_q.report_time_us <= in_q.now_us;
			out_q.changed        <= changed_q;
		end
	end

endmodule

`default_nettype wire
